// ===== rtl/shs_pkg.sv =====
// ---------------------------------------------------------------------------
// Salted hash shard selector package
// Shared types, SHA-256 constants and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegShardCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSalt0      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSalt1      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSalt2      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSalt3      = 3'd4;

  // "shard-route0x": the fixed text between salt and hex key.
  localparam logic [103:0] RouteTag = 104'h73_68_61_72_64_2d_72_6f_75_74_65_30_78;
  localparam logic [7:0]   PadByte  = 8'h80;
  localparam logic [63:0]  MsgBits  = 64'd872;

  localparam logic [7:0][31:0] Iv = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  // Item as it leaves the front end.
  typedef struct packed {
    logic [15:0][31:0] blk1;
    logic [15:0][31:0] blk2;
    logic [31:0]       cnt;
    logic              err;
  } front_item_t;

  // State carried through each hash round stage.
  typedef struct packed {
    logic [7:0][31:0]  v;
    logic [15:0][31:0] w;
    logic [7:0][31:0]  hc;
    logic [15:0][31:0] blk2;
    logic [31:0]       cnt;
    logic              err;
  } round_st_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h57 + {4'd0, n};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/shs_front.sv =====
// ---------------------------------------------------------------------------
// Shard selector front end
// Builds the two padded message blocks of an item and registers them.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  input  wire logic [63:0]         key_0_i,
  input  wire logic [63:0]         key_1_i,
  input  wire logic [63:0]         key_2_i,
  input  wire logic [63:0]         key_3_i,
  input  wire logic [255:0]        salt_i,
  input  wire logic [31:0]         cnt_i,
  output logic                     vld_o,
  output shs_pkg::front_item_t     item_o
);

  logic [1023:0]         msg;
  logic [255:0]          key;
  logic                  vld_q;
  shs_pkg::front_item_t  item_d, item_q;

  always_comb begin
    key = {key_0_i, key_1_i, key_2_i, key_3_i};
    msg = '0;
    msg[1023 -: 256] = salt_i;
    msg[767 -: 104]  = shs_pkg::RouteTag;
    for (int j = 0; j < 32; j++) begin
      msg[1023 - 8 * (45 + 2 * j) -: 8] = shs_pkg::hex_char(key[255 - 8 * j -: 4]);
      msg[1023 - 8 * (46 + 2 * j) -: 8] = shs_pkg::hex_char(key[251 - 8 * j -: 4]);
    end
    msg[1023 - 8 * 109 -: 8] = shs_pkg::PadByte;
    msg[63:0] = shs_pkg::MsgBits;
    for (int i = 0; i < 16; i++) begin
      item_d.blk1[i] = msg[1023 - 32 * i -: 32];
      item_d.blk2[i] = msg[511 - 32 * i -: 32];
    end
    item_d.cnt = cnt_i;
    item_d.err = (cnt_i == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

// ===== rtl/shs_fifo.sv =====
// ---------------------------------------------------------------------------
// Shard selector item queue
// Two-entry queue between the front end and the hash pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  shs_pkg::front_item_t      item_i,
  output logic                      full_o,
  output logic                      vld_o,
  output shs_pkg::front_item_t      item_o
);

  shs_pkg::front_item_t  mem_q [2];
  logic                  wr_q, wr_d, rd_q, rd_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  pop;

  // The pipeline behind never stalls, so an item leaves as soon as it is here.
  assign pop = (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = pop;
  assign item_o = mem_q[rd_q];

endmodule

`default_nettype wire

// ===== rtl/shs_round.sv =====
// ---------------------------------------------------------------------------
// Shard selector hash round
// One registered SHA-256 round with its message schedule step.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_round (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic [31:0]       k_i,
  input  shs_pkg::round_st_t     st_i,
  output logic                   vld_o,
  output shs_pkg::round_st_t     st_o
);

  shs_pkg::round_st_t st_d, st_q;
  logic               vld_q;
  logic [31:0]        s1, ch, t1, s0, maj, t2, ws0, ws1;

  always_comb begin
    s1  = shs_pkg::rotr(st_i.v[4], 6) ^ shs_pkg::rotr(st_i.v[4], 11)
        ^ shs_pkg::rotr(st_i.v[4], 25);
    ch  = (st_i.v[4] & st_i.v[5]) ^ (~st_i.v[4] & st_i.v[6]);
    t1  = st_i.v[7] + s1 + ch + k_i + st_i.w[0];
    s0  = shs_pkg::rotr(st_i.v[0], 2) ^ shs_pkg::rotr(st_i.v[0], 13)
        ^ shs_pkg::rotr(st_i.v[0], 22);
    maj = (st_i.v[0] & st_i.v[1]) ^ (st_i.v[0] & st_i.v[2]) ^ (st_i.v[1] & st_i.v[2]);
    t2  = s0 + maj;
    ws0 = shs_pkg::rotr(st_i.w[1], 7) ^ shs_pkg::rotr(st_i.w[1], 18) ^ (st_i.w[1] >> 3);
    ws1 = shs_pkg::rotr(st_i.w[14], 17) ^ shs_pkg::rotr(st_i.w[14], 19)
        ^ (st_i.w[14] >> 10);
    st_d = st_i;
    st_d.v[0] = t1 + t2;
    st_d.v[1] = st_i.v[0];
    st_d.v[2] = st_i.v[1];
    st_d.v[3] = st_i.v[2];
    st_d.v[4] = st_i.v[3] + t1;
    st_d.v[5] = st_i.v[4];
    st_d.v[6] = st_i.v[5];
    st_d.v[7] = st_i.v[6];
    for (int i = 0; i < 15; i++) begin
      st_d.w[i] = st_i.w[i + 1];
    end
    st_d.w[15] = st_i.w[0] + ws0 + st_i.w[9] + ws1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;

endmodule

`default_nettype wire

// ===== rtl/shs_mod.sv =====
// ---------------------------------------------------------------------------
// Shard selector modulo pipeline
// Restoring 64 by 32 bit remainder, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_mod (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         vld_i,
  input  wire logic [63:0]  dvd_i,
  input  wire logic [31:0]  dsr_i,
  input  wire logic         err_i,
  output logic              vld_o,
  output logic [31:0]       rem_o,
  output logic              err_o
);

  logic [64:0]       vld_q;
  logic [63:0]       dvd_q [65];
  logic [31:0]       rem_q [65];
  logic [31:0]       dsr_q [65];
  logic [64:0]       err_q;

  assign vld_q[0] = vld_i;
  assign dvd_q[0] = dvd_i;
  assign rem_q[0] = 32'd0;
  assign dsr_q[0] = dsr_i;
  assign err_q[0] = err_i;

  for (genvar s = 0; s < 64; s++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] diff;
    always_comb begin
      sh   = {rem_q[s], dvd_q[s][63]};
      diff = sh - {1'b0, dsr_q[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s + 1] <= 1'b0;
      end else begin
        vld_q[s + 1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[s]) begin
        dvd_q[s + 1] <= {dvd_q[s][62:0], 1'b0};
        rem_q[s + 1] <= (sh >= {1'b0, dsr_q[s]}) ? diff[31:0] : sh[31:0];
        dsr_q[s + 1] <= dsr_q[s];
        err_q[s + 1] <= err_q[s];
      end
    end
  end

  assign vld_o = vld_q[64];
  assign rem_o = rem_q[64];
  assign err_o = err_q[64];

endmodule

`default_nettype wire

// ===== rtl/salted_hash_shard_selector_top.sv =====
// ---------------------------------------------------------------------------
// Salted hash shard selector
// Hashes salt, route tag and hex key with SHA-256, picks shard modulo count.
// ---------------------------------------------------------------------------
//  channel   ports                                     handshake
//  input     key_0_i..key_3_i                          start high, busy low
//  result    shard_o, error_o                          done_o strobe, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          cfg_we_i high
//
//  One item is taken per cycle while busy is low; the stages are one to format,
//  one in the queue, 128 round stages plus two feed-forward stages,
//  64 remainder stages and one output register.
//  Reset clears all valid bits and sets shard count to one, salt to zero.
//  The result side cannot stall; busy is raised only if the queue fills.
// ---------------------------------------------------------------------------
`default_nettype none

module salted_hash_shard_selector_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [63:0]                     key_0_i,
  input  wire logic [63:0]                     key_1_i,
  input  wire logic [63:0]                     key_2_i,
  input  wire logic [63:0]                     key_3_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [shs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [63:0]                     cfg_wdata_i,
  output logic                                 done_o,
  output logic [31:0]                          shard_o,
  output logic                                 error_o
);

  logic [31:0]           cnt_q;
  logic [63:0]           salt0_q, salt1_q, salt2_q, salt3_q;
  logic                  acc;
  logic                  fr_vld, q_vld, q_full;
  shs_pkg::front_item_t  fr_item, q_item;

  logic                  b1_vld [65];
  shs_pkg::round_st_t    b1_st  [65];
  logic                  b2_vld [65];
  shs_pkg::round_st_t    b2_st  [65];
  logic                  mid_vld_q, fin_vld_q;
  shs_pkg::round_st_t    mid_q;
  logic [63:0]           fold_q;
  logic [31:0]           fcnt_q;
  logic                  ferr_q;
  logic                  m_vld, m_err;
  logic [31:0]           m_rem;
  logic                  done_q, err_q;
  logic [31:0]           shard_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 32'd1;
      salt0_q <= '0;
      salt1_q <= '0;
      salt2_q <= '0;
      salt3_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        shs_pkg::RegShardCount: cnt_q   <= cfg_wdata_i[31:0];
        shs_pkg::RegSalt0:      salt0_q <= cfg_wdata_i;
        shs_pkg::RegSalt1:      salt1_q <= cfg_wdata_i;
        shs_pkg::RegSalt2:      salt2_q <= cfg_wdata_i;
        shs_pkg::RegSalt3:      salt3_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign acc = start && !busy;

  shs_front u_front (
    .clk_i, .rst_ni,
    .vld_i   (acc),
    .key_0_i, .key_1_i, .key_2_i, .key_3_i,
    .salt_i  ({salt0_q, salt1_q, salt2_q, salt3_q}),
    .cnt_i   (cnt_q),
    .vld_o   (fr_vld),
    .item_o  (fr_item)
  );

  shs_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (fr_vld),
    .item_i  (fr_item),
    .full_o  (q_full),
    .vld_o   (q_vld),
    .item_o  (q_item)
  );

  assign busy = q_full;

  always_comb begin
    b1_vld[0]     = q_vld;
    b1_st[0].v    = shs_pkg::Iv;
    b1_st[0].w    = q_item.blk1;
    b1_st[0].hc   = shs_pkg::Iv;
    b1_st[0].blk2 = q_item.blk2;
    b1_st[0].cnt  = q_item.cnt;
    b1_st[0].err  = q_item.err;
  end

  for (genvar r = 0; r < 64; r++) begin : g_blk1
    shs_round u_round (
      .clk_i, .rst_ni,
      .vld_i (b1_vld[r]),
      .k_i   (shs_pkg::RoundK[r]),
      .st_i  (b1_st[r]),
      .vld_o (b1_vld[r + 1]),
      .st_o  (b1_st[r + 1])
    );
  end

  // Chaining value after the first block, then the second block's words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else begin
      mid_vld_q <= b1_vld[64];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_vld[64]) begin
      for (int i = 0; i < 8; i++) begin
        mid_q.v[i]  <= b1_st[64].v[i] + b1_st[64].hc[i];
        mid_q.hc[i] <= b1_st[64].v[i] + b1_st[64].hc[i];
      end
      mid_q.w    <= b1_st[64].blk2;
      mid_q.blk2 <= b1_st[64].blk2;
      mid_q.cnt  <= b1_st[64].cnt;
      mid_q.err  <= b1_st[64].err;
    end
  end

  assign b2_vld[0] = mid_vld_q;
  assign b2_st[0]  = mid_q;

  for (genvar r = 0; r < 64; r++) begin : g_blk2
    shs_round u_round (
      .clk_i, .rst_ni,
      .vld_i (b2_vld[r]),
      .k_i   (shs_pkg::RoundK[r]),
      .st_i  (b2_st[r]),
      .vld_o (b2_vld[r + 1]),
      .st_o  (b2_st[r + 1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else begin
      fin_vld_q <= b2_vld[64];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_vld[64]) begin
      fold_q <= {b2_st[64].v[0] + b2_st[64].hc[0], b2_st[64].v[1] + b2_st[64].hc[1]};
      fcnt_q <= b2_st[64].cnt;
      ferr_q <= b2_st[64].err;
    end
  end

  shs_mod u_mod (
    .clk_i, .rst_ni,
    .vld_i (fin_vld_q),
    .dvd_i (fold_q),
    .dsr_i (fcnt_q),
    .err_i (ferr_q),
    .vld_o (m_vld),
    .rem_o (m_rem),
    .err_o (m_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      err_q   <= 1'b0;
      shard_q <= '0;
    end else begin
      done_q  <= m_vld;
      err_q   <= m_vld && m_err;
      shard_q <= (m_vld && !m_err) ? m_rem : 32'd0;
    end
  end

  assign done_o  = done_q;
  assign error_o = err_q;
  assign shard_o = shard_q;

`ifndef SYNTH
  a_err_zero_shard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_o |-> (shard_o == 32'd0)) else $error("error item carries nonzero shard");
  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !error_o) else $error("error flag outside a result");
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("item queue filled up");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Salted hash shard selector testbench
// Drives keys through the command port in random bursts and writes the shard
// count and salt registers between phases. The expected shard and error flag
// of each item come from a SHA-256 predictor inside the bench, and every
// strobed result is compared in order against them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam logic [shs_pkg::CfgIdxW-1:0] RegUnused    = 3'd5;
  localparam logic [shs_pkg::CfgIdxW-1:0] RegUnusedTop = 3'd7;
  localparam int unsigned                 DrainWait    = 220;

  typedef struct packed {
    logic [31:0] shard;
    logic        err;
  } route_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [63:0] key_0_i = '0, key_1_i = '0, key_2_i = '0, key_3_i = '0;
  logic cfg_we_i = 1'b0;
  logic [shs_pkg::CfgIdxW-1:0] cfg_idx_i = shs_pkg::RegShardCount;
  logic [63:0] cfg_wdata_i = '0;
  logic busy, done_o, error_o;
  logic [31:0] shard_o;

  salted_hash_shard_selector_top dut (.*);

  logic [255:0] pending_keys [$];
  route_t       routes_due [$];
  logic [31:0]  model_count = 32'd1;
  logic [255:0] model_salt = '0;
  logic         took = 1'b0;
  logic         hold_send = 1'b0;
  int           burst_left = 0, gap_left = 0;
  int           mismatches = 0, checked = 0, errors_seen = 0, phases = 0;

  function automatic logic [31:0] rot_right(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_block(ref logic [31:0] hs [8], input logic [7:0] m [128],
                                    input int base);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {m[base+4*i], m[base+4*i+1], m[base+4*i+2], m[base+4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hs[0]; b = hs[1]; c = hs[2]; d = hs[3];
    e = hs[4]; f = hs[5]; g = hs[6]; hh = hs[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25)) +
           ((e & f) ^ (~e & g)) + RoundConst[i] + w[i];
      t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22)) +
           ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hs[0] += a; hs[1] += b; hs[2] += c; hs[3] += d;
    hs[4] += e; hs[5] += f; hs[6] += g; hs[7] += hh;
  endfunction

  // Shard chosen for one key under the given count and salt.
  function automatic route_t route_key(logic [255:0] pkey, logic [31:0] count,
                                       logic [255:0] salt);
    logic [7:0]   m [128];
    logic [31:0]  hs [8];
    logic [103:0] tag;
    logic [3:0]   nib;
    logic [63:0]  folded;
    route_t       r;
    tag = "shard-route0x";
    r = '0;
    if (count == 0) begin
      r.err = 1'b1;
      return r;
    end
    for (int i = 0; i < 128; i++) m[i] = 8'h00;
    for (int i = 0; i < 32; i++) m[i] = salt[255-8*i -: 8];
    for (int i = 0; i < 13; i++) m[32+i] = tag[103-8*i -: 8];
    for (int i = 0; i < 64; i++) begin
      nib = pkey[255-4*i -: 4];
      m[45+i] = (nib < 10) ? 8'h30 + nib : 8'h57 + nib;
    end
    m[109] = 8'h80;
    for (int i = 0; i < 8; i++) m[120+i] = shs_pkg::MsgBits[63-8*i -: 8];
    hs = InitHash;
    sha_block(hs, m, 0);
    sha_block(hs, m, 64);
    folded = {hs[0], hs[1]};
    r.shard = 32'(folded % {32'd0, count});
    return r;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Acceptance, predictor update and result checking, all at the rising edge.
  always @(posedge clk_i) begin
    route_t exp_r;
    took <= start && !busy;
    if (rst_ni && start && !busy)
      routes_due.push_back(route_key({key_0_i, key_1_i, key_2_i, key_3_i},
                                     model_count, model_salt));
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        shs_pkg::RegShardCount: model_count = cfg_wdata_i[31:0];
        shs_pkg::RegSalt0:      model_salt[255:192] = cfg_wdata_i;
        shs_pkg::RegSalt1:      model_salt[191:128] = cfg_wdata_i;
        shs_pkg::RegSalt2:      model_salt[127:64] = cfg_wdata_i;
        shs_pkg::RegSalt3:      model_salt[63:0] = cfg_wdata_i;
        default: ;
      endcase
    end
    if (rst_ni && done_o) begin
      if (routes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: shard %0d error %0b", shard_o, error_o);
      end else begin
        exp_r = routes_due.pop_front();
        checked++;
        if (error_o) errors_seen++;
        if (shard_o !== exp_r.shard || error_o !== exp_r.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected shard %0d error %0b, got shard %0d error %0b",
                     exp_r.shard, exp_r.err, shard_o, error_o);
        end
      end
    end
  end

  // The sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    logic [255:0] k;
    if (rst_ni && !(start && !took)) begin
      if (hold_send || gap_left > 0 || pending_keys.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        k = pending_keys.pop_front();
        {key_0_i, key_1_i, key_2_i, key_3_i} <= k;
        start <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 25) : $urandom_range(0, 2);
      end
    end
  end

  task automatic write_reg(logic [shs_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic set_salt(logic [255:0] s);
    write_reg(shs_pkg::RegSalt0, s[255:192]);
    write_reg(shs_pkg::RegSalt1, s[191:128]);
    write_reg(shs_pkg::RegSalt2, s[127:64]);
    write_reg(shs_pkg::RegSalt3, s[63:0]);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      pending_keys.push_back({rand64(), rand64(), rand64(), rand64()});
  endtask

  // Wait until the sender has emptied its queue and every result is back.
  task automatic drain();
    wait (pending_keys.size() == 0 && !start);
    wait (routes_due.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    phases++;
  endtask

  initial begin
    logic [31:0] count;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first: one shard, zero salt, then extreme keys and four random keys.
    pending_keys.push_back('0);
    pending_keys.push_back('1);
    pending_keys.push_back({64{4'ha}});
    pending_keys.push_back({64{4'h5}});
    for (int i = 0; i < 256; i += 37) pending_keys.push_back(256'd1 << i);
    queue_random(4);
    drain();

    // A zero shard count must flag an error.
    write_reg(shs_pkg::RegShardCount, 64'd0);
    pending_keys.push_back('0);
    pending_keys.push_back('1);
    queue_random(3);
    drain();

    // Largest count, salt all ones; the top half of the data word is dropped.
    write_reg(shs_pkg::RegShardCount, {32'hffff_ffff, 32'hffff_ffff});
    set_salt('1);
    pending_keys.push_back('0);
    pending_keys.push_back('1);
    queue_random(3);
    drain();

    // Writes to an unused index must leave the registers alone.
    write_reg(RegUnused, 64'd0);
    write_reg(RegUnusedTop, rand64());
    write_reg(shs_pkg::RegShardCount, 64'd1);
    queue_random(3);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: count = $urandom_range(2, 16);
        1: count = $urandom();
        2: count = 32'hffff_ffff - $urandom_range(0, 3);
        default: count = (p == 7) ? 32'd0 : $urandom_range(1, 1000);
      endcase
      write_reg(shs_pkg::RegShardCount, {$urandom(), count});
      set_salt({rand64(), rand64(), rand64(), rand64()});
      queue_random(100);
      if (p == 4) begin
        // Pause the sender half way until the pipeline has fully emptied.
        wait (pending_keys.size() < 50);
        hold_send = 1'b1;
        wait (!start && routes_due.size() == 0);
        hold_send = 1'b0;
      end
      drain();
    end

    $display("Checked %0d results over %0d register phases, %0d with the error flag.",
             checked, phases, errors_seen);
    $display("Mismatches counted: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding.", routes_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
